// ----- hdl/sxk_pkg.sv -----
// ----------------------------------------------------------------------------
// sxk_pkg
// Shared constants and the letter-frequency weight table for the XOR key search.
// ----------------------------------------------------------------------------
package sxk_pkg;

  localparam int SCORE_WIDTH_DEF = 24;
  localparam int BYTE_W          = 8;
  localparam int KEY_COUNT       = 256;
  localparam int OUT_SCORE_W     = 24;
  localparam int WEIGHT_W        = 14;
  localparam int LETTER_IDX_W    = 5;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd122;
  localparam logic [BYTE_W-1:0] LOWER_A  = 8'd97;

  // English letter weights a..z, fixed point with 16 fraction bits
  function automatic logic [WEIGHT_W-1:0] letter_weight(input logic [LETTER_IDX_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    case (idx)
      5'd0:    w = 14'd5352;
      5'd1:    w = 14'd978;
      5'd2:    w = 14'd1823;
      5'd3:    w = 14'd2787;
      5'd4:    w = 14'd8324;
      5'd5:    w = 14'd1460;
      5'd6:    w = 14'd1321;
      5'd7:    w = 14'd3994;
      5'd8:    w = 14'd4565;
      5'd9:    w = 14'd100;
      5'd10:   w = 14'd506;
      5'd11:   w = 14'd2638;
      5'd12:   w = 14'd1577;
      5'd13:   w = 14'd4423;
      5'd14:   w = 14'd4920;
      5'd15:   w = 14'd1264;
      5'd16:   w = 14'd62;
      5'd17:   w = 14'd3924;
      5'd18:   w = 14'd4146;
      5'd19:   w = 14'd5935;
      5'd20:   w = 14'd1807;
      5'd21:   w = 14'd641;
      5'd22:   w = 14'd1547;
      5'd23:   w = 14'd98;
      5'd24:   w = 14'd1294;
      5'd25:   w = 14'd48;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/sxk_if.sv -----
// ----------------------------------------------------------------------------
// sxk_if
// Valid/ready channels for ciphertext bytes in and key results out.
// ----------------------------------------------------------------------------
interface sxk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       last_byte;

  modport source (output valid, output cipher_byte, output last_byte, input ready);
  modport sink   (input valid, input cipher_byte, input last_byte, output ready);
endinterface

interface sxk_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  best_key;
  logic [23:0] best_score;

  modport source (output valid, output best_key, output best_score, input ready);
  modport sink   (input valid, input best_key, input best_score, output ready);
endinterface

// ----- hdl/sxk_cell.sv -----
// ----------------------------------------------------------------------------
// sxk_cell
// One candidate key: running score and invalid flag, plus one stage of the
// best-key scan that ripples down the row of cells.
// ----------------------------------------------------------------------------
module sxk_cell #(
  parameter int SCORE_WIDTH = sxk_pkg::SCORE_WIDTH_DEF,
  parameter logic [sxk_pkg::BYTE_W-1:0] KEY = '0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        upd,
  input  logic [sxk_pkg::BYTE_W-1:0]  cipher_byte,
  input  logic                        tok_valid_in,
  input  logic [sxk_pkg::BYTE_W-1:0]  tok_key_in,
  input  logic [SCORE_WIDTH-1:0]      tok_score_in,
  output logic                        tok_valid_out,
  output logic [sxk_pkg::BYTE_W-1:0]  tok_key_out,
  output logic [SCORE_WIDTH-1:0]      tok_score_out
);

  logic [SCORE_WIDTH-1:0]             score;
  logic                               invalid;
  logic [sxk_pkg::BYTE_W-1:0]         plain;
  logic [sxk_pkg::BYTE_W-1:0]         letter;
  logic [SCORE_WIDTH:0]               sum;
  logic [SCORE_WIDTH-1:0]             score_next;
  logic                               bad;
  logic [SCORE_WIDTH-1:0]             eff;

  assign plain  = cipher_byte ^ KEY;
  assign bad    = (plain < sxk_pkg::PRINT_LO) || (plain > sxk_pkg::PRINT_HI);
  assign letter = plain - sxk_pkg::LOWER_A;
  assign sum    = {1'b0, score}
                + (SCORE_WIDTH + 1)'(sxk_pkg::letter_weight(letter[sxk_pkg::LETTER_IDX_W-1:0]));
  assign score_next = sum[SCORE_WIDTH] ? {SCORE_WIDTH{1'b1}} : sum[SCORE_WIDTH-1:0];
  assign eff    = invalid ? '0 : score;

  always_ff @(posedge clk) begin
    if (rst) begin
      score   <= '0;
      invalid <= 1'b0;
    end else if (tok_valid_in) begin
      // scan passes this cell: clear for the next message
      score   <= '0;
      invalid <= 1'b0;
    end else if (upd) begin
      if (bad) begin
        invalid <= 1'b1;
      end else if (plain >= sxk_pkg::LOWER_A) begin
        score <= score_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else begin
      tok_valid_out <= tok_valid_in;
    end
  end

  // strictly greater: lower key keeps a tie
  always_ff @(posedge clk) begin
    if (eff > tok_score_in) begin
      tok_key_out   <= KEY;
      tok_score_out <= eff;
    end else begin
      tok_key_out   <= tok_key_in;
      tok_score_out <= tok_score_in;
    end
  end

endmodule

// ----- hdl/single_byte_xor_key_search.sv -----
// ----------------------------------------------------------------------------
// single_byte_xor_key_search
// Single-byte XOR key search by English letter-frequency scoring.
// ----------------------------------------------------------------------------
// din takes one ciphertext byte per item, last_byte marking the end of a
// message. All 256 candidate keys are scored in parallel by a row of cells,
// so message bytes are taken at one item per cycle unless a scan blocks din.
// The item flagged last_byte starts a scan that ripples through the row, one
// cell per cycle, carrying the best key so far; each cell clears its state
// as the scan passes. The result reaches dout through the start register, the
// 256 cells, a holding and an output register, and din.ready stays low from
// the last byte until the result moves into the output register.
// The scan length is set by the row.
// dout is a registered output: a stalled receiver holds the result there
// while din takes the next message; a further result waits in a holding
// register, and din stays blocked until it can move to the output.
// Reset clears every key score, every invalid flag and all valid flags.
// The result is the lowest key with the highest positive score, or key 0
// with score 0 if no key scores; the score saturates at 24 bits.
// ----------------------------------------------------------------------------
module single_byte_xor_key_search #(
  parameter int SCORE_WIDTH = sxk_pkg::SCORE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sxk_in_if.sink           din,
  sxk_out_if.source        dout
);

  localparam int BW = sxk_pkg::BYTE_W;
  localparam int NK = sxk_pkg::KEY_COUNT;
  localparam int OW = sxk_pkg::OUT_SCORE_W;

  logic                   busy;
  logic                   scan_start;
  logic                   pend_valid;
  logic [BW-1:0]          pend_key;
  logic [SCORE_WIDTH-1:0] pend_score;
  logic [OW-1:0]          pend_score_out;
  logic                   out_valid;
  logic [BW-1:0]          out_key;
  logic [OW-1:0]          out_score;
  logic                   in_acc;
  logic                   move_out;

  logic                   tok_valid [NK+1];
  logic [BW-1:0]          tok_key   [NK+1];
  logic [SCORE_WIDTH-1:0] tok_score [NK+1];

  assign din.ready = !busy;
  assign in_acc    = din.valid && !busy;
  assign move_out  = pend_valid && (!out_valid || dout.ready);

  assign tok_valid[0] = scan_start;
  assign tok_key[0]   = '0;
  assign tok_score[0] = '0;

  for (genvar k = 0; k < NK; k++) begin : g_cell
    sxk_cell #(
      .SCORE_WIDTH (SCORE_WIDTH),
      .KEY         (BW'(k))
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .upd           (in_acc),
      .cipher_byte   (din.cipher_byte),
      .tok_valid_in  (tok_valid[k]),
      .tok_key_in    (tok_key[k]),
      .tok_score_in  (tok_score[k]),
      .tok_valid_out (tok_valid[k+1]),
      .tok_key_out   (tok_key[k+1]),
      .tok_score_out (tok_score[k+1])
    );
  end

  if (SCORE_WIDTH > OW) begin : g_sat
    assign pend_score_out = (|pend_score[SCORE_WIDTH-1:OW]) ? {OW{1'b1}}
                                                             : pend_score[OW-1:0];
  end else begin : g_ext
    assign pend_score_out = OW'(pend_score);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      scan_start <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      scan_start <= in_acc && din.last_byte;
      if (in_acc && din.last_byte) begin
        busy <= 1'b1;
      end else if (move_out) begin
        busy <= 1'b0;
      end
      if (tok_valid[NK]) begin
        pend_valid <= 1'b1;
      end else if (move_out) begin
        pend_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid[NK]) begin
      pend_key   <= tok_key[NK];
      pend_score <= tok_score[NK];
    end
    if (move_out) begin
      out_key   <= pend_key;
      out_score <= pend_score_out;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.best_key   = out_key;
  assign dout.best_score = out_score;

endmodule

// ----- bench/single_byte_xor_key_search_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_byte_xor_key_search_tb
// Self-checking bench for the single-byte XOR key search.
// ----------------------------------------------------------------------------
// Ciphertext messages are streamed into the search one item at a time with
// random gaps. A behavioural scorer in the bench keeps its own per-key totals
// and invalid flags and predicts the best key and score for each message.
// Every result is checked field by field in arrival order.
// The stimulus covers two groups:
// - short directed messages: extreme bytes, all keys invalid, text under
//   keys 0xFF and 0x00, a tie and the printable-range edges;
// - random messages, mostly English-like text under a random key.
// At one point the result side holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module single_byte_xor_key_search_tb;

  localparam int SCORE_W        = sxk_pkg::SCORE_WIDTH_DEF;
  localparam int OUT_W          = sxk_pkg::OUT_SCORE_W;
  localparam int GAP_MAX        = 10;
  localparam int LONG_HOLD      = 3000;
  localparam int HOLD_AFTER     = 8;
  localparam int SCAN_SETTLE    = 300;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int RANDOM_BYTES   = 1080;

  localparam logic [7:0] PLAIN_MIN = 8'd32;
  localparam logic [7:0] PLAIN_MAX = 8'd122;
  localparam logic [7:0] PLAIN_A   = 8'd97;

  localparam logic [OUT_W-1:0] OUT_CAP = '1;

  localparam logic [13:0] LETTER_WT [26] = '{
    14'd5352, 14'd978, 14'd1823, 14'd2787, 14'd8324, 14'd1460, 14'd1321,
    14'd3994, 14'd4565, 14'd100, 14'd506, 14'd2638, 14'd1577, 14'd4423,
    14'd4920, 14'd1264, 14'd62, 14'd3924, 14'd4146, 14'd5935, 14'd1807,
    14'd641, 14'd1547, 14'd98, 14'd1294, 14'd48
  };

  typedef struct {
    logic [7:0] cbyte;
    logic       last;
  } cipher_item_t;

  typedef struct {
    logic [7:0]       key;
    logic [OUT_W-1:0] score;
  } key_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sxk_in_if  din_if ();
  sxk_out_if dout_if ();

  single_byte_xor_key_search uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always #1 clk = ~clk;

  cipher_item_t       pending_bytes [$];
  key_result_t        expected_best [$];
  logic [SCORE_W-1:0] key_total [256];
  bit                 key_bad [256];

  int n_msgs       = 0;
  int n_bytes_sent = 0;
  int n_results    = 0;
  int n_fail       = 0;
  int n_in_stall   = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  bit send_burst   = 1'b0;
  bit recv_burst   = 1'b0;
  bit hold_done    = 1'b0;

  function automatic void clear_keys();
    for (int k = 0; k < 256; k++) begin
      key_total[k] = '0;
      key_bad[k]   = 1'b0;
    end
  endfunction

  // Per-key update for one ciphertext byte; on the last byte pick the winner
  task automatic score_cipher_byte(input logic [7:0] cbyte, input logic last);
    logic [7:0]         plain;
    logic [SCORE_W:0]   sum;
    logic [SCORE_W-1:0] s;
    logic [SCORE_W-1:0] top_score;
    logic [7:0]         top_key;
    key_result_t        res;
    for (int k = 0; k < 256; k++) begin
      plain = cbyte ^ k[7:0];
      if (plain < PLAIN_MIN || plain > PLAIN_MAX) begin
        key_bad[k] = 1'b1;
      end else if (plain >= PLAIN_A) begin
        sum = key_total[k] + LETTER_WT[5'(plain - PLAIN_A)];
        key_total[k] = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
      end
    end
    if (!last) return;
    top_score = '0;
    top_key   = 8'd0;
    for (int k = 0; k < 256; k++) begin
      s = key_bad[k] ? '0 : key_total[k];
      if (s > top_score) begin
        top_score = s;
        top_key   = k[7:0];
      end
    end
    res.key   = top_key;
    res.score = (top_score > OUT_CAP) ? OUT_CAP : OUT_W'(top_score);
    expected_best.push_back(res);
    clear_keys();
  endtask

  function automatic logic [7:0] plain_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return PLAIN_A + 8'($urandom_range(0, 25));
    if (r < 70) return PLAIN_MIN;
    return 8'($urandom_range(32, 122));
  endfunction

  task automatic queue_message(input logic [7:0] body [$]);
    cipher_item_t itm;
    for (int i = 0; i < body.size(); i++) begin
      itm.cbyte = body[i];
      itm.last  = (i == body.size() - 1);
      pending_bytes.push_back(itm);
    end
    n_msgs++;
  endtask

  // Sender
  always @(posedge clk) begin
    cipher_item_t nxt;
    if (rst) begin
      din_if.valid <= 1'b0;
      send_gap     <= 0;
    end else if (!din_if.valid || din_if.ready) begin
      if (din_if.valid) begin
        score_cipher_byte(din_if.cipher_byte, din_if.last_byte);
        n_bytes_sent++;
      end
      if (send_gap != 0 || pending_bytes.size() == 0) begin
        din_if.valid <= 1'b0;
        if (send_gap != 0) send_gap <= send_gap - 1;
      end else begin
        nxt = pending_bytes.pop_front();
        din_if.valid       <= 1'b1;
        din_if.cipher_byte <= nxt.cbyte;
        din_if.last_byte   <= nxt.last;
        if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
        send_gap <= send_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
    end else begin
      n_in_stall++;
    end
  end

  // Receiver and result check
  always @(posedge clk) begin
    key_result_t want;
    int          g;
    if (rst) begin
      dout_if.ready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        n_results <= n_results + 1;
        if (expected_best.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: unexpected result key %0d score %0d", $realtime,
                     dout_if.best_key, dout_if.best_score);
          n_fail++;
        end else begin
          want = expected_best.pop_front();
          if (dout_if.best_key !== want.key || dout_if.best_score !== want.score) begin
            if (n_fail < 10)
              $display("%0t: result %0d: key exp %0d got %0d, score exp %0d got %0d",
                       $realtime, n_results, want.key, dout_if.best_key,
                       want.score, dout_if.best_score);
            n_fail++;
          end
        end
        if ($urandom_range(0, 19) == 0) recv_burst <= !recv_burst;
        g = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
      end else begin
        g = (recv_gap != 0) ? recv_gap - 1 : 0;
      end
      recv_gap      <= g;
      dout_if.ready <= (g == 0) && (hold_left == 0);
    end
  end

  // Long result-side hold-off, once, so that the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= HOLD_AFTER) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("** single_byte_xor_key_search: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] msg [$];
    string      txt;
    int         len;
    int         kind;
    int         r;
    int         random_bytes;
    logic [7:0] key;

    din_if.valid       = 1'b0;
    din_if.cipher_byte = 8'd0;
    din_if.last_byte   = 1'b0;
    dout_if.ready      = 1'b0;
    clear_keys();

    // single-byte messages at both byte extremes
    msg = {8'h00};
    queue_message(msg);
    msg = {8'hFF};
    queue_message(msg);
    // every key invalid: no key scores
    msg = {8'h00, 8'h80};
    queue_message(msg);
    txt = "zap qj";
    msg = {};
    for (int i = 0; i < txt.len(); i++) msg.push_back(txt[i] ^ 8'hFF);
    queue_message(msg);
    txt = "one";
    msg = {};
    for (int i = 0; i < txt.len(); i++) msg.push_back(txt[i]);
    queue_message(msg);
    // two distinct bytes: keys k and k^3 tie
    msg = {8'h41, 8'h42};
    queue_message(msg);
    // printable-range edges
    msg = {8'h7A, 8'h20, 8'h1F, 8'h7B};
    queue_message(msg);

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      r    = $urandom_range(0, 9);
      len  = (r < 6) ? $urandom_range(1, 8) :
             (r < 9) ? $urandom_range(9, 40) : $urandom_range(41, 120);
      if ($urandom_range(0, 9) == 0) key = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else key = 8'($urandom);
      msg = {};
      for (int i = 0; i < len; i++)
        msg.push_back((kind == 0) ? 8'($urandom) : (plain_char() ^ key));
      if (kind == 1) msg[$urandom_range(0, len - 1)] = 8'($urandom);
      queue_message(msg);
      random_bytes += len;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || din_if.valid) @(negedge clk);
    while (expected_best.size() != 0) @(negedge clk);
    repeat (SCAN_SETTLE) @(posedge clk);

    $display("Streamed %0d messages (%0d bytes), %0d results checked",
             n_msgs, n_bytes_sent, n_results);
    $display("Input stalled for %0d cycles, incl. one long result hold-off", n_in_stall);
    if (n_fail == 0 && expected_best.size() == 0) begin
      $display("** single_byte_xor_key_search: PASSED **");
    end else begin
      $display("%0d failures, %0d results still awaited", n_fail, expected_best.size());
      $display("** single_byte_xor_key_search: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sxk_pkg.sv
hdl/sxk_if.sv
hdl/sxk_cell.sv
hdl/single_byte_xor_key_search.sv
bench/single_byte_xor_key_search_tb.sv
